// ----- hw/rtl/sbus_frame_receiver_unit_macros.svh -----
// ----------------------------------------------------------------------------
// sbus frame receiver assertion macros
// shared property wrappers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SBUS_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define SFR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfr same-cycle check failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfr next-cycle check failed");

`endif

// ----- hw/rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// types, constants and helpers shared by the sbus frame receiver modules
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0] START_BYTE  = 8'h0F;
  localparam int unsigned FRAME_BYTES = 25;
  // frame bytes 1..23 are kept: channel data plus the flag byte
  localparam int unsigned STORE_BYTES = 23;
  localparam int unsigned STORE_W     = STORE_BYTES * 8;

  localparam logic [7:0] END_PLAIN = 8'h00;
  localparam logic [7:0] END_ALT0  = 8'h04;
  localparam logic [7:0] END_ALT1  = 8'h14;
  localparam logic [7:0] END_ALT2  = 8'h24;
  localparam logic [7:0] END_ALT3  = 8'h34;

  localparam int unsigned RAW_W   = 11;
  localparam int unsigned PULSE_W = 12;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned FLAG_W  = 4;
  localparam int unsigned TMO_W   = 16;

  localparam logic [PULSE_W-1:0] PULSE_BASE  = 12'd880;
  localparam logic [TMO_W-1:0]   TIMEOUT_RST = 16'd100;
  localparam logic [TMO_W-1:0]   ELAPSED_MAX = 16'hFFFF;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_CHANNEL = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  // classified item handed from the front to the back
  typedef struct packed {
    kind_e             kind;
    logic [FLAG_W-1:0] flags;
  } sfr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sfr_qstat_t;

  typedef struct packed {
    kind_e              kind;
    logic [IDX_W-1:0]   idx;
    logic [RAW_W-1:0]   raw;
    logic [PULSE_W-1:0] pulse;
    logic [FLAG_W-1:0]  flags;
    logic               healthy;
    logic               last;
  } sfr_result_t;

  function automatic logic end_byte_ok(input logic [7:0] v);
    return (v == END_PLAIN) || (v == END_ALT0) || (v == END_ALT1) ||
           (v == END_ALT2) || (v == END_ALT3);
  endfunction

  // round(raw * 0.625) + 880, ties up
  function automatic logic [PULSE_W-1:0] pulse_of(input logic [RAW_W-1:0] raw);
    logic [13:0] x5;
    logic [13:0] sum;
    x5  = {1'b0, raw, 2'b00} + {3'b000, raw};
    sum = x5 + 14'd4;
    return {1'b0, sum[13:3]} + PULSE_BASE;
  endfunction

endpackage

// ----- hw/rtl/sfr_front.sv -----
// ----------------------------------------------------------------------------
// sfr_front
// takes bytes and ticks, hunts for the start byte, collects the frame and
// pushes ticks and valid frames into the queue
// ----------------------------------------------------------------------------
module sfr_front #(
  parameter int unsigned DW = 176
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [7:0]            rx_byte_i,
  input  sfr_pkg::sfr_qstat_t   qstat_i,
  output logic                  push_o,
  output sfr_pkg::sfr_cmd_t     push_cmd_o,
  output logic [DW-1:0]         push_data_o
);

  logic [4:0]                 pos_q, pos_d;
  logic [sfr_pkg::STORE_W-1:0] store_q, store_d;
  logic accept, is_tick, take, final_byte;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign is_tick    = (command_i == sfr_pkg::CMD_TICK);
  assign take       = accept && !is_tick && ((pos_q != 5'd0) || (rx_byte_i == sfr_pkg::START_BYTE));
  assign final_byte = (pos_q == 5'(sfr_pkg::FRAME_BYTES - 1));

  always_comb begin
    pos_d   = pos_q;
    store_d = store_q;
    if (take) begin
      pos_d = final_byte ? 5'd0 : pos_q + 5'd1;
      // start and end bytes are not kept, byte 1 ends up in the low bits
      if ((pos_q != 5'd0) && !final_byte) begin
        store_d = {rx_byte_i, store_q[sfr_pkg::STORE_W-1:8]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 5'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  assign push_o = accept &&
                  (is_tick || (take && final_byte && sfr_pkg::end_byte_ok(rx_byte_i)));
  assign push_cmd_o.kind  = is_tick ? sfr_pkg::KIND_STATUS : sfr_pkg::KIND_CHANNEL;
  assign push_cmd_o.flags = store_q[sfr_pkg::STORE_W-8 +: sfr_pkg::FLAG_W];
  assign push_data_o      = store_q[DW-1:0];

endmodule

// ----- hw/rtl/sfr_queue.sv -----
// ----------------------------------------------------------------------------
// sfr_queue
// short first-in first-out buffer between the front and the back
// ----------------------------------------------------------------------------
module sfr_queue #(
  parameter int unsigned W = 181
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [W-1:0]        push_data_i,
  input  logic                pop_i,
  output logic [W-1:0]        pop_data_o,
  output sfr_pkg::sfr_qstat_t qstat_o
);

  localparam int unsigned PW = $clog2(sfr_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(sfr_pkg::QUEUE_DEPTH + 1);

  logic [W-1:0]  mem_q [sfr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign qstat_o.full  = (cnt_q == CW'(sfr_pkg::QUEUE_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign pop_data_o    = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(sfr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(sfr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/sfr_back.sv -----
// ----------------------------------------------------------------------------
// sfr_back
// link supervision and result generation: one status per tick, one channel
// result per cycle while the output is not stalled, for a valid frame
// ----------------------------------------------------------------------------
module sfr_back #(
  parameter int unsigned CHANNEL_COUNT = 16,
  parameter int unsigned DW            = 176
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sfr_pkg::sfr_qstat_t             qstat_i,
  input  sfr_pkg::sfr_cmd_t               pop_cmd_i,
  input  logic [DW-1:0]                   pop_data_i,
  output logic                            pop_o,
  input  logic [sfr_pkg::TMO_W-1:0]       timeout_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sfr_pkg::sfr_result_t            result_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  localparam logic [sfr_pkg::IDX_W-1:0] LAST_CH = sfr_pkg::IDX_W'(CHANNEL_COUNT - 1);

  state_e                        state_q, state_d;
  logic [sfr_pkg::TMO_W-1:0]     elapsed_q, elapsed_d, elapsed_inc;
  logic                          seen_q, seen_d;
  logic [sfr_pkg::FLAG_W-1:0]    flags_q, flags_d;
  logic [DW-1:0]                 chan_q, chan_d;
  logic [sfr_pkg::IDX_W-1:0]     ch_q, ch_d;
  logic                          out_valid_q, out_valid_d;
  sfr_pkg::sfr_result_t          res_q, res_d;
  logic                          slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign elapsed_inc = (elapsed_q == sfr_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;

  always_comb begin
    state_d     = state_q;
    elapsed_d   = elapsed_q;
    seen_d      = seen_q;
    flags_d     = flags_q;
    chan_d      = chan_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    pop_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty && slot_free) begin
          pop_o = 1'b1;
          if (pop_cmd_i.kind == sfr_pkg::KIND_STATUS) begin
            elapsed_d     = elapsed_inc;
            res_d.kind    = sfr_pkg::KIND_STATUS;
            res_d.idx     = '0;
            res_d.raw     = '0;
            res_d.pulse   = sfr_pkg::PULSE_BASE;
            res_d.flags   = flags_q;
            res_d.healthy = seen_q && (elapsed_inc < timeout_i);
            res_d.last    = 1'b1;
            out_valid_d   = 1'b1;
          end else begin
            flags_d   = pop_cmd_i.flags;
            elapsed_d = '0;
            seen_d    = 1'b1;
            chan_d    = pop_data_i;
            ch_d      = '0;
            state_d   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          res_d.kind    = sfr_pkg::KIND_CHANNEL;
          res_d.idx     = ch_q;
          res_d.raw     = chan_q[sfr_pkg::RAW_W-1:0];
          res_d.pulse   = sfr_pkg::pulse_of(chan_q[sfr_pkg::RAW_W-1:0]);
          res_d.flags   = flags_q;
          // elapsed was just cleared, so only a zero timeout fails
          res_d.healthy = (timeout_i != '0);
          res_d.last    = (ch_q == LAST_CH);
          out_valid_d   = 1'b1;
          chan_d        = chan_q >> sfr_pkg::RAW_W;
          ch_d          = ch_q + 4'd1;
          if (ch_q == LAST_CH) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      elapsed_q   <= '0;
      seen_q      <= 1'b0;
      flags_q     <= '0;
      chan_q      <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      seen_q      <= seen_d;
      flags_q     <= flags_d;
      chan_q      <= chan_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// ----- hw/rtl/sbus_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// sbus_frame_receiver_unit
// sbus frame receiver with link supervision, top level
// ----------------------------------------------------------------------------
// Each item is a received byte or a one millisecond tick. The front collects
// the 25-byte frame and, on a valid end byte, queues the frame together with
// ticks in a two-entry queue. The back turns a tick into one status result in
// the cycle after it leaves the queue, and a valid frame into CHANNEL_COUNT
// channel results, one per cycle while the output is not stalled, after a
// loading step. Input stalls only while the queue is full. Results leave
// through an output register. The timeout register may be written at any time
// the block is idle.
// ----------------------------------------------------------------------------
module sbus_frame_receiver_unit #(
  parameter int unsigned CHANNEL_COUNT = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sfr_pkg::TMO_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              kind_o,
  output logic [sfr_pkg::IDX_W-1:0]         channel_index_o,
  output logic [sfr_pkg::RAW_W-1:0]         channel_raw_o,
  output logic [sfr_pkg::PULSE_W-1:0]       pulse_us_o,
  output logic                              digital_17_o,
  output logic                              digital_18_o,
  output logic                              frame_lost_o,
  output logic                              failsafe_flag_o,
  output logic                              link_healthy_o,
  output logic                              last_o
);

  localparam int unsigned DW = CHANNEL_COUNT * sfr_pkg::RAW_W;
  localparam int unsigned QW = DW + $bits(sfr_pkg::sfr_cmd_t);

  logic [sfr_pkg::TMO_W-1:0] timeout_q;
  sfr_pkg::sfr_qstat_t       qstat;
  logic                      push, pop;
  sfr_pkg::sfr_cmd_t         push_cmd, pop_cmd;
  logic [DW-1:0]             push_data, pop_data;
  logic [QW-1:0]             pop_word;
  sfr_pkg::sfr_result_t      result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= sfr_pkg::TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  sfr_front #(
    .DW (DW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .rx_byte_i   (rx_byte_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .push_data_o (push_data)
  );

  sfr_queue #(
    .W (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_cmd, push_data}),
    .pop_i       (pop),
    .pop_data_o  (pop_word),
    .qstat_o     (qstat)
  );

  assign pop_cmd  = pop_word[QW-1:DW];
  assign pop_data = pop_word[DW-1:0];

  sfr_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .DW            (DW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .pop_cmd_i   (pop_cmd),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .timeout_i   (timeout_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign kind_o          = result.kind;
  assign channel_index_o = result.idx;
  assign channel_raw_o   = result.raw;
  assign pulse_us_o      = result.pulse;
  assign digital_17_o    = result.flags[0];
  assign digital_18_o    = result.flags[1];
  assign frame_lost_o    = result.flags[2];
  assign failsafe_flag_o = result.flags[3];
  assign link_healthy_o  = result.healthy;
  assign last_o          = result.last;

endmodule

// ----- hw/rtl/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// sfr_checker
// port-level checks on the result stream of the sbus frame receiver
// ----------------------------------------------------------------------------
`include "sbus_frame_receiver_unit_macros.svh"

module sfr_checker #(
  parameter int unsigned CHANNEL_COUNT = 16
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        kind_o,
  input logic [sfr_pkg::IDX_W-1:0]   channel_index_o,
  input logic [sfr_pkg::RAW_W-1:0]   channel_raw_o,
  input logic [sfr_pkg::PULSE_W-1:0] pulse_us_o,
  input logic                        last_o
);

  // a stalled item holds
  `SFR_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(channel_raw_o) && $stable(pulse_us_o))

  // status items carry the fixed zero channel
  `SFR_ASSERT_IMPLY(a_status_fixed, out_valid_o && kind_o == sfr_pkg::KIND_STATUS, last_o && channel_index_o == '0 && channel_raw_o == '0 && pulse_us_o == sfr_pkg::PULSE_BASE)

  // last marks exactly the final channel
  `SFR_ASSERT_IMPLY(a_last_chan, out_valid_o && kind_o == sfr_pkg::KIND_CHANNEL, last_o == (channel_index_o == sfr_pkg::IDX_W'(CHANNEL_COUNT - 1)))

  // channels of one frame follow back to back in order
  `SFR_ASSERT_NEXT(a_chan_seq, out_valid_o && !out_stall_i && kind_o == sfr_pkg::KIND_CHANNEL && !last_o, out_valid_o && kind_o == sfr_pkg::KIND_CHANNEL && channel_index_o == $past(channel_index_o) + 4'd1)

endmodule

bind sbus_frame_receiver_unit sfr_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_sfr_checker (.*);

// ----- tb/sv/sbus_frame_receiver_unit_checker.sv -----
// ----------------------------------------------------------------------------
// sbus_frame_receiver_unit_checker
// watches the config, byte/tick and result channels of the frame receiver,
// predicts every result from the accepted items and compares field by field
// ----------------------------------------------------------------------------
module sbus_frame_receiver_unit_checker #(
  parameter int unsigned CHANNEL_COUNT = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [sfr_pkg::TMO_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        command_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        kind_i,
  input  logic [sfr_pkg::IDX_W-1:0]   channel_index_i,
  input  logic [sfr_pkg::RAW_W-1:0]   channel_raw_i,
  input  logic [sfr_pkg::PULSE_W-1:0] pulse_us_i,
  input  logic                        digital_17_i,
  input  logic                        digital_18_i,
  input  logic                        frame_lost_i,
  input  logic                        failsafe_flag_i,
  input  logic                        link_healthy_i,
  input  logic                        last_i,
  output int                          mismatch_count_o,
  output int                          pending_o,
  output int                          checked_o
);

  localparam int MAX_PRINT = 40;

  // receiver state as seen from outside
  logic [4:0]                byte_pos;
  logic [7:0]                frame_bytes [0:24];
  logic [3:0]                flag_bits;
  logic [15:0]               elapsed_ms;
  logic                      seen_valid;
  logic [15:0]               timeout_ms;

  sfr_pkg::sfr_result_t      expected_q [$];
  int                        mismatch_cnt = 0;
  int                        checked_cnt = 0;

  assign mismatch_count_o = mismatch_cnt;
  assign checked_o        = checked_cnt;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    if (mismatch_cnt < MAX_PRINT) begin
      $display("mismatch on result %0d: %s got %0d expected %0d", checked_cnt, what, got, want);
    end
    mismatch_cnt++;
  endtask

  function automatic sfr_pkg::sfr_result_t result_of(input sfr_pkg::kind_e k,
                                                     input logic [3:0] idx,
                                                     input logic [10:0] raw,
                                                     input logic is_last);
    sfr_pkg::sfr_result_t r;
    logic [31:0]          p;
    p = {21'd0, raw};
    p = ((p * 5) + 4) >> 3;
    p = p + 32'd880;
    r.kind    = k;
    r.idx     = idx;
    r.raw     = raw;
    r.pulse   = p[11:0];
    r.flags   = flag_bits;
    r.healthy = seen_valid && (elapsed_ms < timeout_ms);
    r.last    = is_last;
    return r;
  endfunction

  // 11-bit channels packed lsb first from frame byte 1 on
  function automatic logic [10:0] channel_value(input int unsigned ch);
    int unsigned bit_off;
    int unsigned b;
    logic [23:0] win;
    bit_off = ch * 11;
    b       = 1 + bit_off / 8;
    win     = {frame_bytes[b+2], frame_bytes[b+1], frame_bytes[b]};
    win     = win >> (bit_off % 8);
    return win[10:0];
  endfunction

  function automatic logic end_byte_valid(input logic [7:0] v);
    case (v)
      sfr_pkg::END_PLAIN, sfr_pkg::END_ALT0, sfr_pkg::END_ALT1,
      sfr_pkg::END_ALT2, sfr_pkg::END_ALT3: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic take_tick();
    if (elapsed_ms != sfr_pkg::ELAPSED_MAX) elapsed_ms++;
    expected_q.push_back(result_of(sfr_pkg::KIND_STATUS, 4'd0, 11'd0, 1'b1));
  endtask

  task automatic take_byte(input logic [7:0] b);
    int unsigned ch;
    if (byte_pos == 0 && b != sfr_pkg::START_BYTE) return;
    frame_bytes[byte_pos] = b;
    byte_pos++;
    if (byte_pos < sfr_pkg::FRAME_BYTES) return;
    byte_pos = 0;
    if (!end_byte_valid(frame_bytes[sfr_pkg::FRAME_BYTES-1])) return;
    flag_bits  = frame_bytes[23][3:0];
    elapsed_ms = 0;
    seen_valid = 1'b1;
    for (ch = 0; ch < CHANNEL_COUNT; ch++) begin
      expected_q.push_back(result_of(sfr_pkg::KIND_CHANNEL, ch[3:0], channel_value(ch),
                                     ch == CHANNEL_COUNT - 1));
    end
  endtask

  task automatic compare_result(input sfr_pkg::sfr_result_t want);
    if (kind_i !== want.kind)                report("kind", kind_i, want.kind);
    if (channel_index_i !== want.idx)        report("channel_index", channel_index_i, want.idx);
    if (channel_raw_i !== want.raw)          report("channel_raw", channel_raw_i, want.raw);
    if (pulse_us_i !== want.pulse)           report("pulse_us", pulse_us_i, want.pulse);
    if (digital_17_i !== want.flags[0])      report("digital_17", digital_17_i, want.flags[0]);
    if (digital_18_i !== want.flags[1])      report("digital_18", digital_18_i, want.flags[1]);
    if (frame_lost_i !== want.flags[2])      report("frame_lost", frame_lost_i, want.flags[2]);
    if (failsafe_flag_i !== want.flags[3])   report("failsafe_flag", failsafe_flag_i, want.flags[3]);
    if (link_healthy_i !== want.healthy)     report("link_healthy", link_healthy_i, want.healthy);
    if (last_i !== want.last)                report("last", last_i, want.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos   = '0;
      flag_bits  = '0;
      elapsed_ms = '0;
      seen_valid = 1'b0;
      timeout_ms = sfr_pkg::TIMEOUT_RST;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) timeout_ms = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report("result with nothing expected, kind", kind_i, 16'd0);
        end else begin
          compare_result(expected_q.pop_front());
        end
        checked_cnt++;
      end
      if (in_valid_i && !in_stall_i) begin
        if (command_i == sfr_pkg::CMD_TICK) take_tick();
        else take_byte(rx_byte_i);
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- tb/sv/sbus_frame_receiver_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sbus_frame_receiver_unit_tb
// drives bytes, ticks and timeout writes into the frame receiver with bursty
// input and a wandering output stall; the checker beside it does the scoring
// ----------------------------------------------------------------------------
module sbus_frame_receiver_unit_tb;

  localparam int unsigned CHANNEL_COUNT = 16;
  localparam int CLK_PERIOD    = 10;
  localparam int LIMIT_CYCLES  = 50_000;
  localparam int SETTLE_CYCLES = 2 * CHANNEL_COUNT + 8;
  localparam int RANDOM_ITEMS  = 12;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ONES   = 1;
  localparam int FILL_START  = 2;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [sfr_pkg::TMO_W-1:0]   cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic                        command_i = 1'b0;
  logic [7:0]                  rx_byte_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        kind_o;
  logic [sfr_pkg::IDX_W-1:0]   channel_index_o;
  logic [sfr_pkg::RAW_W-1:0]   channel_raw_o;
  logic [sfr_pkg::PULSE_W-1:0] pulse_us_o;
  logic                        digital_17_o;
  logic                        digital_18_o;
  logic                        frame_lost_o;
  logic                        failsafe_flag_o;
  logic                        link_healthy_o;
  logic                        last_o;

  int mismatches;
  int pending;
  int checked;

  int items_sent = 0;
  int ticks_sent = 0;
  int frames_sent = 0;
  int good_frames = 0;
  int cfg_writes = 0;
  int burst_left = 0;
  int unsigned rx_window = 0;
  int unsigned rx_mode = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sbus_frame_receiver_unit #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .channel_index_o(channel_index_o),
    .channel_raw_o  (channel_raw_o),
    .pulse_us_o     (pulse_us_o),
    .digital_17_o   (digital_17_o),
    .digital_18_o   (digital_18_o),
    .frame_lost_o   (frame_lost_o),
    .failsafe_flag_o(failsafe_flag_o),
    .link_healthy_o (link_healthy_o),
    .last_o         (last_o)
  );

  sbus_frame_receiver_unit_checker #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) frame_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .command_i       (command_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_i          (kind_o),
    .channel_index_i (channel_index_o),
    .channel_raw_i   (channel_raw_o),
    .pulse_us_i      (pulse_us_o),
    .digital_17_i    (digital_17_o),
    .digital_18_i    (digital_18_o),
    .frame_lost_i    (frame_lost_o),
    .failsafe_flag_i (failsafe_flag_o),
    .link_healthy_i  (link_healthy_o),
    .last_i          (last_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // output stall switches between random modes over windows of random length
  always @(posedge clk_i) begin
    if (rx_window == 0) begin
      rx_window <= $urandom_range(16, 96);
      rx_mode   <= $urandom_range(0, 3);
    end else begin
      rx_window <= rx_window - 1;
    end
    case (rx_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  task automatic send_item(input sfr_pkg::cmd_e cmd, input logic [7:0] b);
    int   gap;
    logic st;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    rx_byte_i  <= b;
    do begin
      @(negedge clk_i);
      st = in_stall_o;
      @(posedge clk_i);
    end while (st);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(sfr_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
    ticks_sent++;
  endtask

  // bytes outside a frame that never look like a start byte
  task automatic send_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = $urandom_range(0, 255);
      if (b == sfr_pkg::START_BYTE) b = ~b;
      send_item(sfr_pkg::CMD_BYTE, b);
    end
  endtask

  function automatic logic [7:0] data_byte(input int mode);
    case (mode)
      FILL_ONES:  return 8'hFF;
      FILL_START: return sfr_pkg::START_BYTE;
      default: begin
        case ($urandom_range(0, 7))
          0: return sfr_pkg::START_BYTE;
          1: return 8'h00;
          2: return 8'hFF;
          default: return 8'($urandom_range(0, 255));
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] good_end();
    case ($urandom_range(0, 4))
      0: return sfr_pkg::END_PLAIN;
      1: return sfr_pkg::END_ALT0;
      2: return sfr_pkg::END_ALT1;
      3: return sfr_pkg::END_ALT2;
      default: return sfr_pkg::END_ALT3;
    endcase
  endfunction

  function automatic bit is_good_end(input logic [7:0] v);
    return v == sfr_pkg::END_PLAIN || v == sfr_pkg::END_ALT0 || v == sfr_pkg::END_ALT1 ||
           v == sfr_pkg::END_ALT2 || v == sfr_pkg::END_ALT3;
  endfunction

  // start byte, 22 data bytes, flag byte, end byte; ticks may fall in between
  task automatic send_frame(input int mode, input logic [7:0] flag_byte,
                            input logic [7:0] end_byte, input int tick_pct);
    int i;
    send_item(sfr_pkg::CMD_BYTE, sfr_pkg::START_BYTE);
    for (i = 1; i < sfr_pkg::FRAME_BYTES; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      if (i == 23) send_item(sfr_pkg::CMD_BYTE, flag_byte);
      else if (i == 24) send_item(sfr_pkg::CMD_BYTE, end_byte);
      else send_item(sfr_pkg::CMD_BYTE, data_byte(mode));
    end
    frames_sent++;
    if (is_good_end(end_byte)) good_frames++;
  endtask

  task automatic send_good_frame(input int tick_pct);
    send_frame(FILL_RANDOM, 8'($urandom_range(0, 255)), good_end(), tick_pct);
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    logic idle;
    in_valid_i <= 1'b0;
    do begin
      @(negedge clk_i);
      idle = (pending == 0);
      @(posedge clk_i);
    end while (!idle);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic random_chunk(input int quota);
    int start_items;
    int r;
    start_items = items_sent;
    while (items_sent - start_items < quota) begin
      r = $urandom_range(0, 9);
      if (r <= 5) begin
        send_good_frame(10);
      end else if (r == 6) begin
        send_frame(FILL_RANDOM, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 10);
      end else if (r <= 8) begin
        repeat ($urandom_range(1, 6)) send_tick();
      end else begin
        send_noise($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timeout, no frame seen yet
    send_tick();
    send_item(sfr_pkg::CMD_BYTE, 8'h00);
    send_item(sfr_pkg::CMD_BYTE, 8'hFF);
    send_frame(FILL_ONES, 8'hFF, sfr_pkg::END_PLAIN, 0);
    send_tick();
    // start bytes inside a frame are data; bad end byte drops it
    send_frame(FILL_START, 8'h05, sfr_pkg::START_BYTE, 0);
    send_tick();
    drain();

    // health runs out on the third tick
    write_timeout(16'd3);
    send_good_frame(0);
    repeat (4) send_tick();
    drain();

    // zero timeout: never healthy
    write_timeout(16'd0);
    send_good_frame(0);
    send_tick();
    drain();

    write_timeout(16'($urandom_range(1, 10)));
    random_chunk(RANDOM_ITEMS);
    drain();

    write_timeout(sfr_pkg::TIMEOUT_RST);
    send_tick();
    drain();

    $display("covered %0d items: %0d ticks, %0d frames (%0d with a good end byte), %0d timeouts",
             items_sent, ticks_sent, frames_sent, good_frames, cfg_writes);
    $display("%0d results checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
